/* design/mstt_pkg.sv */
// mstt_pkg: shared types and constants of the multi-slot timer table
// request kinds, result status codes, controller states, command and status structs
// no dependencies

package mstt_pkg;

   localparam logic [1:0] KIND_TICK       = 2'd0;
   localparam logic [1:0] KIND_START      = 2'd1;
   localparam logic [1:0] KIND_CANCEL     = 2'd2;
   localparam logic [1:0] KIND_CANCEL_ALL = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_FREE = 2'd1;
   localparam logic [1:0] STATUS_BAD     = 2'd2;

   localparam logic       UNITS_MS  = 1'b0;
   localparam logic [7:0] NO_TIMER  = 8'hFF;

   localparam int MS_PER_SEC  = 1000;
   localparam int RECIP_SHIFT = 24;
   localparam int TICK_W      = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_MUL,
      ST_DIV_QUO,
      ST_DIV_FIX,
      ST_SCAN,
      ST_EMIT,
      ST_SINGLE
   } state_type;

   typedef struct packed {
      logic load;
      logic tick_go;
      logic scan;
      logic emit;
      logic single;
   } cmd_type;

   typedef struct packed {
      logic paused;
      logic scan_last;
      logic scan_hits;
      logic hit_single;
      logic out_free;
   } sts_type;

endpackage

/* design/multi_slot_timer_table.sv */
// multi_slot_timer_table: top level of the timer slot table
// ties the controller to the datapath; depends on mstt_pkg, mstt_ctrl, mstt_datapath
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+--------------------------------------------
//   req      | in        | req_valid/req_ready | kind, period_units, period_amount,
//            |           |                     | periodic, target_slot
//   rsp      | out       | rsp_valid/rsp_ready | status, slot, expired, last,
//            |           |                     | active_count, tick_count
//
// one request at a time; req_ready is high only while the controller is idle
// tick: a slot scan with one ram read per slot, then one result beat per expired slot;
//   a paused tick gives no result beat and leaves the counter as it is
// start: runs the three-stage ms-to-tick conversion before its result beat; cancel: no conversion
// a result beat waits in the output register; a stalled rsp holds the next beat back
// synchronous reset clears the active bits, counter and pause flag; no clearing pass

module multi_slot_timer_table #(
   parameter int SLOTS   = 16,
   parameter int TICK_MS = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic        req_period_units,
   input  logic [15:0] req_period_amount,
   input  logic        req_periodic,
   input  logic [7:0]  req_target_slot,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_slot,
   output logic        rsp_expired,
   output logic        rsp_last,
   output logic [4:0]  rsp_active_count,
   output logic [15:0] rsp_tick_count
);

   mstt_pkg::cmd_type cmd;
   mstt_pkg::sts_type sts;

   mstt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .sts       (sts),
      .cmd       (cmd)
   );

   mstt_datapath #(
      .SLOTS   (SLOTS),
      .TICK_MS (TICK_MS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_kind          (req_kind),
      .req_period_units  (req_period_units),
      .req_period_amount (req_period_amount),
      .req_periodic      (req_periodic),
      .req_target_slot   (req_target_slot),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_slot          (rsp_slot),
      .rsp_expired       (rsp_expired),
      .rsp_last          (rsp_last),
      .rsp_active_count  (rsp_active_count),
      .rsp_tick_count    (rsp_tick_count)
   );

endmodule

/* design/mstt_ram.sv */
// mstt_ram: generic single write port, single read port ram with registered read
// used for the slot mode, period and expiry store; no dependencies

module mstt_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/mstt_ctrl.sv */
// mstt_ctrl: controller state machine of the timer table
// sequences request accept, period conversion, slot scan and result beats
// depends on mstt_pkg

module mstt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_kind,
   input  mstt_pkg::sts_type sts,
   output mstt_pkg::cmd_type cmd
);

   mstt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mstt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = (state_ff == mstt_pkg::ST_IDLE);
      case (state_ff)
         mstt_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               case (req_kind)
                  mstt_pkg::KIND_TICK: begin
                     if (!sts.paused) begin
                        cmd.tick_go = 1'b1;
                        state_in    = mstt_pkg::ST_SCAN;
                     end
                  end
                  mstt_pkg::KIND_START: state_in = mstt_pkg::ST_DIV_MUL;
                  default:              state_in = mstt_pkg::ST_SINGLE;
               endcase
            end
         end
         mstt_pkg::ST_DIV_MUL: state_in = mstt_pkg::ST_DIV_QUO;
         mstt_pkg::ST_DIV_QUO: state_in = mstt_pkg::ST_DIV_FIX;
         mstt_pkg::ST_DIV_FIX: state_in = mstt_pkg::ST_SINGLE;
         mstt_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) begin
               state_in = sts.scan_hits ? mstt_pkg::ST_EMIT : mstt_pkg::ST_IDLE;
            end
         end
         mstt_pkg::ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.hit_single) begin
                  state_in = mstt_pkg::ST_IDLE;
               end
            end
         end
         mstt_pkg::ST_SINGLE: begin
            if (sts.out_free) begin
               cmd.single = 1'b1;
               state_in   = mstt_pkg::ST_IDLE;
            end
         end
         default: state_in = mstt_pkg::ST_IDLE;
      endcase
   end

endmodule

/* design/mstt_datapath.sv */
// mstt_datapath: slot table, tick counter, period conversion and result register
// holds active bits in flops and mode, period and expiry in one mstt_ram
// depends on mstt_pkg and mstt_ram

module mstt_datapath #(
   parameter int SLOTS   = 16,
   parameter int TICK_MS = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  mstt_pkg::cmd_type cmd,
   output mstt_pkg::sts_type sts,
   input  logic [1:0]        req_kind,
   input  logic              req_period_units,
   input  logic [15:0]       req_period_amount,
   input  logic              req_periodic,
   input  logic [7:0]        req_target_slot,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [3:0]        rsp_slot,
   output logic              rsp_expired,
   output logic              rsp_last,
   output logic [4:0]        rsp_active_count,
   output logic [15:0]       rsp_tick_count
);

   localparam int IDXW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNTW  = $clog2(SLOTS + 1);
   localparam int TW    = mstt_pkg::TICK_W;
   localparam int RECW  = mstt_pkg::RECIP_SHIFT + 1;
   localparam int PRODW = RECW + TW;
   localparam int REMW  = TW + 10;
   localparam int WORDW = 1 + TW + TW;
   localparam logic [RECW-1:0] RECIP =
      RECW'((64'd1 << mstt_pkg::RECIP_SHIFT) / TICK_MS);
   localparam logic [TW-1:0] SEC_MULT = TW'(mstt_pkg::MS_PER_SEC / TICK_MS);
   localparam logic [TW-1:0] TICK_LEN = TW'(TICK_MS);
   localparam logic [7:0]    SLOTS_B  = 8'(SLOTS);

   // request latch
   logic [1:0]       kind_ff, kind_in;
   logic             units_ff, units_in;
   logic [TW-1:0]    amt_ff, amt_in;
   logic             mode_ff, mode_in;
   logic [7:0]       target_ff, target_in;

   // period conversion pipe
   logic [PRODW-1:0] prod_ff, prod_in;
   logic [TW-1:0]    quo_ff, quo_in;
   logic [TW-1:0]    period_ff, period_in;

   // table state
   logic [SLOTS-1:0] active_ff, active_in;
   logic [SLOTS-1:0] hits_ff, hits_in;
   logic [IDXW-1:0]  idx_ff, idx_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;
   logic [TW-1:0]    counter_ff, counter_in;
   logic             paused_ff, paused_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [3:0]       rsp_slot_ff, rsp_slot_in;
   logic             rsp_expired_ff, rsp_expired_in;
   logic             rsp_last_ff, rsp_last_in;
   logic [4:0]       rsp_active_ff, rsp_active_in;
   logic [TW-1:0]    rsp_tick_ff, rsp_tick_in;

   logic [REMW-1:0]  quo_by_len;
   logic [REMW-1:0]  rem;
   logic [TW-1:0]    ms_period;
   logic [TW-1:0]    sec_period;

   logic             free_found;
   logic [IDXW-1:0]  free_idx;
   logic [IDXW-1:0]  hit_idx;
   logic             hit_single;
   logic             scan_last;
   logic             scan_hit;
   logic [CNTW-1:0]  cnt_next;
   logic [IDXW-1:0]  tgt_idx;

   logic             wr_en;
   logic [IDXW-1:0]  wr_addr;
   logic [WORDW-1:0] wr_data;
   logic             rd_en;
   logic [IDXW-1:0]  rd_addr;
   logic [WORDW-1:0] rd_data;
   logic             rd_periodic;
   logic [TW-1:0]    rd_period;
   logic [TW-1:0]    rd_expiry;

   mstt_ram #(
      .WIDTH (WORDW),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_periodic = rd_data[WORDW-1];
   assign rd_period   = rd_data[2*TW-1:TW];
   assign rd_expiry   = rd_data[TW-1:0];

   assign scan_last = (idx_ff == IDXW'(SLOTS - 1));
   assign scan_hit  = active_ff[idx_ff] && (rd_expiry == counter_ff);
   assign rd_en     = cmd.tick_go | (cmd.scan & ~scan_last);
   assign rd_addr   = cmd.tick_go ? '0 : IDXW'(idx_ff + IDXW'(1));
   assign tgt_idx   = target_ff[IDXW-1:0];

   // milliseconds to ticks: reciprocal estimate, then one correction step
   assign prod_in    = PRODW'(amt_ff) * PRODW'(RECIP);
   assign quo_in     = prod_ff[mstt_pkg::RECIP_SHIFT +: TW];
   assign quo_by_len = REMW'(quo_ff) * REMW'(TICK_LEN);
   assign rem        = REMW'(amt_ff) - quo_by_len;
   assign ms_period  = (amt_ff < TICK_LEN) ? TW'(1)
                     : TW'(quo_ff + TW'(rem >= REMW'(TICK_LEN)));
   assign sec_period = amt_ff * SEC_MULT;
   assign period_in  = (units_ff == mstt_pkg::UNITS_MS) ? ms_period : sec_period;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      hit_idx    = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDXW'(i);
         end
         if (hits_ff[i]) begin
            hit_idx = IDXW'(i);
         end
      end
   end

   assign hit_single = ((hits_ff & (hits_ff - SLOTS'(1))) == '0);
   assign cnt_next   = active_ff[idx_ff] ? CNTW'(cnt_ff + CNTW'(1)) : cnt_ff;

   always_comb begin
      kind_in        = kind_ff;
      units_in       = units_ff;
      amt_in         = amt_ff;
      mode_in        = mode_ff;
      target_in      = target_ff;
      active_in      = active_ff;
      hits_in        = hits_ff;
      idx_in         = idx_ff;
      cnt_in         = cnt_ff;
      counter_in     = counter_ff;
      paused_in      = paused_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_expired_in = rsp_expired_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_active_in  = rsp_active_ff;
      rsp_tick_in    = rsp_tick_ff;
      wr_en          = 1'b0;
      wr_addr        = idx_ff;
      wr_data        = {rd_periodic, rd_period, TW'(counter_ff + rd_period)};

      if (cmd.load) begin
         kind_in   = req_kind;
         units_in  = req_period_units;
         amt_in    = req_period_amount;
         mode_in   = req_periodic;
         target_in = req_target_slot;
      end

      if (cmd.tick_go) begin
         counter_in = TW'(counter_ff + TW'(1));
         idx_in     = '0;
         cnt_in     = '0;
         hits_in    = '0;
      end

      if (cmd.scan) begin
         cnt_in = cnt_next;
         if (scan_hit) begin
            hits_in[idx_ff] = 1'b1;
            if (rd_periodic) begin
               wr_en = 1'b1;
            end else begin
               active_in[idx_ff] = 1'b0;
            end
         end
         if (scan_last) begin
            if (cnt_next == '0) begin
               paused_in = 1'b1;
            end
         end else begin
            idx_in = IDXW'(idx_ff + IDXW'(1));
         end
      end

      if (cmd.emit) begin
         hits_in[hit_idx] = 1'b0;
         rsp_valid_in     = 1'b1;
         rsp_status_in    = mstt_pkg::STATUS_OK;
         rsp_slot_in      = 4'(hit_idx);
         rsp_expired_in   = 1'b1;
         rsp_last_in      = hit_single;
         rsp_active_in    = 5'(cnt_ff);
         rsp_tick_in      = counter_ff;
      end

      if (cmd.single) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = mstt_pkg::STATUS_OK;
         rsp_slot_in    = '0;
         rsp_expired_in = 1'b0;
         rsp_last_in    = 1'b1;
         rsp_active_in  = '0;
         rsp_tick_in    = counter_ff;
         case (kind_ff)
            mstt_pkg::KIND_START: begin
               if (free_found) begin
                  active_in[free_idx] = 1'b1;
                  paused_in           = 1'b0;
                  wr_en               = 1'b1;
                  wr_addr             = free_idx;
                  wr_data             = {mode_ff, period_ff, TW'(counter_ff + period_ff)};
                  rsp_slot_in         = 4'(free_idx);
               end else begin
                  rsp_status_in = mstt_pkg::STATUS_NO_FREE;
               end
            end
            mstt_pkg::KIND_CANCEL: begin
               if (target_ff == mstt_pkg::NO_TIMER) begin
                  rsp_status_in = mstt_pkg::STATUS_OK;
               end else if (target_ff >= SLOTS_B) begin
                  rsp_status_in = mstt_pkg::STATUS_BAD;
               end else if (active_ff[tgt_idx]) begin
                  active_in[tgt_idx] = 1'b0;
                  rsp_slot_in        = 4'(target_ff);
               end else begin
                  rsp_status_in = mstt_pkg::STATUS_BAD;
                  rsp_slot_in   = 4'(target_ff);
               end
            end
            mstt_pkg::KIND_CANCEL_ALL: begin
               active_in = '0;
            end
            default: begin
               rsp_status_in = mstt_pkg::STATUS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         counter_ff   <= '0;
         paused_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         counter_ff   <= counter_in;
         paused_ff    <= paused_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      units_ff       <= units_in;
      amt_ff         <= amt_in;
      mode_ff        <= mode_in;
      target_ff      <= target_in;
      prod_ff        <= prod_in;
      quo_ff         <= quo_in;
      period_ff      <= period_in;
      hits_ff        <= hits_in;
      idx_ff         <= idx_in;
      cnt_ff         <= cnt_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_expired_ff <= rsp_expired_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_active_ff  <= rsp_active_in;
      rsp_tick_ff    <= rsp_tick_in;
   end

   assign sts.paused     = paused_ff;
   assign sts.scan_last  = scan_last;
   assign sts.scan_hits  = (|hits_ff) | scan_hit;
   assign sts.hit_single = hit_single;
   assign sts.out_free   = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_expired      = rsp_expired_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_active_count = rsp_active_ff;
   assign rsp_tick_count   = rsp_tick_ff;

   // a result is loaded only when the output register can take it
   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit || cmd.single) |-> (~rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending beat");

   // an expiry beat always has a pending hit behind it
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (hits_ff != '0))
      else $error("expiry beat with no hit recorded");

   // the tick counter moves only on an unpaused tick
   assert property (@(posedge clock) disable iff (reset)
      !cmd.tick_go |=> (counter_ff == $past(counter_ff)))
      else $error("tick counter moved without a tick");

   // a successful start claims exactly one more slot
   assert property (@(posedge clock) disable iff (reset)
      (cmd.single && (kind_ff == mstt_pkg::KIND_START) && free_found)
      |=> ($countones(active_ff) == $past($countones(active_ff)) + 1))
      else $error("start did not claim a slot");

endmodule
